### src/fp8a_pkg.sv
// ----------------------------------------------------------------------------
// FP8 E4M3 arithmetic package
// Shared types, operation codes and constants for the FP8 E4M3 unit.
// ----------------------------------------------------------------------------
`default_nettype none
package fp8a_pkg;

  localparam int ActionWidth = 3;
  localparam int DataWidth   = 8;
  localparam int ManMask     = 'h07;
  localparam int ManBits     = 3;
  localparam int ExpFieldMax = 'hF;
  localparam int ExpBias     = 7;

  typedef enum logic [ActionWidth-1:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_NEG = 3'd4
  } action_t;

  localparam logic [DataWidth-1:0] NanPos = 8'h7F;
  localparam logic [DataWidth-1:0] NanNeg = 8'hFF;

  // Pre-rounding form: value = mant/64 * 2^exp, with sticky for lost bits.
  typedef struct packed {
    logic                 done;
    logic [DataWidth-1:0] fixed;
    logic                 sign;
    logic signed [6:0]    exp;
    logic [9:0]           mant;
    logic                 sticky;
  } pre_t;

endpackage
`default_nettype wire

### src/fp8a_front.sv
// ----------------------------------------------------------------------------
// FP8 front end
// Unpacks, treats special operands and forms the raw sum, product or
// quotient with its exponent and sticky bit.
// ----------------------------------------------------------------------------
`default_nettype none
module fp8a_front (
  input  wire logic [2:0]     action,
  input  wire logic [7:0]     a,
  input  wire logic [7:0]     b,
  output fp8a_pkg::pre_t      pre
);

  function automatic logic is_nan(input logic [7:0] x);
    return x[6:0] == 7'h7F;
  endfunction

  function automatic logic is_zero(input logic [7:0] x);
    return x[6:0] == 7'h00;
  endfunction

  // Normalised significand (hidden bit at bit 3) and unbiased exponent.
  function automatic logic [8:0] norm_in(input logic [7:0] x);
    logic [3:0]        m;
    logic signed [4:0] e;
    m = {(x[6:3] != 4'd0), x[2:0]};
    e = (x[6:3] != 4'd0) ? 5'(signed'({1'b0, x[6:3]}) - 5'sd7) : -5'sd6;
    for (int i = 0; i < 4; i++) begin
      if (m < 4'd8) begin
        m = m << 1;
        e = e - 5'sd1;
      end
    end
    return {m, e};
  endfunction

  function automatic logic [6:0] jam(input logic [6:0] m, input logic [4:0] sh);
    logic [6:0] mask;
    if (sh > 5'd7) return {6'd0, (m != 7'd0)};
    mask = 7'((8'd1 << sh) - 8'd1);
    return (m >> sh) | {6'd0, ((m & mask) != 7'd0)};
  endfunction

  // Quotient table for normalised significands 8 to 15: each entry holds
  // floor(64 * ma / mb) and, above it, a flag for a nonzero remainder.
  function automatic logic [511:0] div_table();
    logic [511:0] t;
    logic [9:0]   n;
    logic [4:0]   r;
    logic [9:0]   q;
    t = '0;
    for (int ia = 0; ia < 8; ia++) begin
      for (int ib = 0; ib < 8; ib++) begin
        n = {4'(8 + ia), 6'd0};
        r = '0;
        q = '0;
        for (int k = 9; k >= 0; k--) begin
          r = {r[3:0], n[k]};
          if (r >= 5'(8 + ib)) begin
            r    = r - 5'(8 + ib);
            q[k] = 1'b1;
          end
        end
        t[(ia * 8 + ib) * 8 +: 8] = {(r != 5'd0), q[6:0]};
      end
    end
    return t;
  endfunction

  localparam logic [511:0] DivTab = div_table();

  logic [7:0]        bb;
  logic [3:0]        ma, mb;
  logic signed [4:0] ea, eb;
  logic [6:0]        xa, xb;
  logic [7:0]        sum;
  logic [8:0]        na, nb;
  logic [7:0]        prod;
  logic [7:0]        dq;

  always_comb begin
    pre = '0;
    bb  = (action == fp8a_pkg::ACT_SUB) ? (b ^ 8'h80) : b;
    ma  = {(a[6:3] != 4'd0), a[2:0]};
    mb  = {(bb[6:3] != 4'd0), bb[2:0]};
    ea  = (a[6:3] != 4'd0) ? 5'(signed'({1'b0, a[6:3]}) - 5'sd7) : -5'sd6;
    eb  = (bb[6:3] != 4'd0) ? 5'(signed'({1'b0, bb[6:3]}) - 5'sd7) : -5'sd6;
    xa  = {ma, 3'd0};
    xb  = {mb, 3'd0};
    sum = '0;
    na  = norm_in(a);
    nb  = norm_in(b);
    prod = na[8:5] * nb[8:5];
    dq   = DivTab[{na[7:5], nb[7:5], 3'b000} +: 8];
    unique case (action)
      fp8a_pkg::ACT_ADD, fp8a_pkg::ACT_SUB: begin
        if (action == fp8a_pkg::ACT_SUB && ((a == fp8a_pkg::NanPos && b == fp8a_pkg::NanNeg)
            || (a == fp8a_pkg::NanNeg && b == fp8a_pkg::NanPos))) begin
          pre.done = 1'b1; pre.fixed = fp8a_pkg::NanPos;
        end else if (is_nan(a)) begin
          pre.done = 1'b1; pre.fixed = a;
        end else if (is_nan(bb)) begin
          pre.done = 1'b1; pre.fixed = bb;
        end else begin
          if (ea > eb) begin
            xb = jam(xb, 5'(ea - eb));
            eb = ea;
          end else if (eb > ea) begin
            xa = jam(xa, 5'(eb - ea));
            ea = eb;
          end
          if (a[7] == bb[7]) begin
            sum = {1'b0, xa} + {1'b0, xb}; pre.sign = a[7];
          end else if (xa > xb) begin
            sum = {1'b0, xa - xb}; pre.sign = a[7];
          end else begin
            sum = {1'b0, xb - xa}; pre.sign = bb[7];
          end
          pre.exp  = 7'(ea);
          pre.mant = {2'd0, sum};
          if (sum == 8'd0) begin
            pre.done = 1'b1; pre.fixed = 8'h00;
          end
        end
      end
      fp8a_pkg::ACT_MUL: begin
        if (is_nan(a) || is_nan(b)) begin
          pre.done = 1'b1; pre.fixed = fp8a_pkg::NanPos;
        end else if (is_zero(a) || is_zero(b)) begin
          pre.done = 1'b1; pre.fixed = 8'h00;
        end else begin
          pre.sign = a[7] ^ b[7];
          pre.exp  = 7'(signed'(na[4:0])) + 7'(signed'(nb[4:0]));
          pre.mant = {2'd0, prod};
        end
      end
      fp8a_pkg::ACT_DIV: begin
        pre.sign = a[7] ^ b[7];
        if (is_nan(a)) begin
          pre.done = 1'b1; pre.fixed = a;
        end else if (is_nan(b)) begin
          pre.done = 1'b1; pre.fixed = b;
        end else if (is_zero(b)) begin
          pre.done = 1'b1;
          pre.fixed = (is_zero(a) || !pre.sign) ? fp8a_pkg::NanPos : fp8a_pkg::NanNeg;
        end else if (is_zero(a)) begin
          pre.done = 1'b1; pre.fixed = 8'h00;
        end else begin
          pre.exp    = 7'(signed'(na[4:0])) - 7'(signed'(nb[4:0]));
          pre.mant   = {3'd0, dq[6:0]};
          pre.sticky = dq[7];
        end
      end
      fp8a_pkg::ACT_NEG: begin
        pre.done = 1'b1; pre.fixed = a ^ 8'h80;
      end
      default: begin
        pre.done = 1'b1; pre.fixed = fp8a_pkg::NanPos;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/fp8a_norm.sv
// ----------------------------------------------------------------------------
// FP8 normaliser
// Brings the significand into the range 64 to 127, adjusting the exponent.
// ----------------------------------------------------------------------------
`default_nettype none
module fp8a_norm (
  input  fp8a_pkg::pre_t pre_in,
  output fp8a_pkg::pre_t pre_out
);

  always_comb begin
    pre_out = pre_in;
    for (int i = 0; i < 3; i++) begin
      if (pre_out.mant >= 10'd128) begin
        pre_out.sticky = pre_out.sticky | pre_out.mant[0];
        pre_out.mant   = pre_out.mant >> 1;
        pre_out.exp    = pre_out.exp + 7'sd1;
      end
    end
    for (int i = 0; i < 7; i++) begin
      if (pre_out.mant != 10'd0 && pre_out.mant < 10'd64) begin
        pre_out.mant = pre_out.mant << 1;
        pre_out.exp  = pre_out.exp - 7'sd1;
      end
    end
  end

endmodule
`default_nettype wire

### src/fp8a_round.sv
// ----------------------------------------------------------------------------
// FP8 rounder
// Denormalises small results, rounds to nearest even and packs the code.
// ----------------------------------------------------------------------------
`default_nettype none
module fp8a_round (
  input  fp8a_pkg::pre_t pre,
  output logic [7:0]     res
);

  logic [6:0]        m;
  logic              st;
  logic [3:0]        sh;
  logic              inc;
  logic [4:0]        r;
  logic signed [6:0] e;

  always_comb begin
    m   = pre.mant[6:0];
    st  = pre.sticky;
    e   = pre.exp;
    sh  = '0;
    r   = '0;
    inc = 1'b0;
    if (pre.done) begin
      res = pre.fixed;
    end else if (pre.mant == 10'd0 || e < -7'sd10) begin
      res = {pre.sign, 7'd0};
    end else begin
      if (e < -7'sd6) begin
        sh = 4'(-7'sd6 - e);
        st = st | ((m & 7'((8'd1 << sh) - 8'd1)) != 7'd0);
        m  = m >> sh;
      end
      st  = st | m[0];
      inc = m[2] && (m[1] || st || m[3]);
      r   = {1'b0, m[6:3]} + {4'd0, inc};
      if (sh != 4'd0) begin
        res = (r >= 5'd8) ? {pre.sign, 7'h08} : {pre.sign, 4'd0, r[2:0]};
      end else begin
        if (r >= 5'd16) begin
          r = r >> 1;
          e = e + 7'sd1;
        end
        e = e + 7'(fp8a_pkg::ExpBias);
        if (e > 7'(fp8a_pkg::ExpFieldMax))
          res = pre.sign ? fp8a_pkg::NanNeg : fp8a_pkg::NanPos;
        else
          res = {pre.sign, e[3:0], r[2:0]};
      end
    end
  end

endmodule
`default_nettype wire

### src/fp8_e4m3_arith_unit.sv
// ----------------------------------------------------------------------------
// FP8 E4M3 arithmetic unit
// Four-stage pipelined add, subtract, multiply, divide and negate.
// ----------------------------------------------------------------------------
// One item enters per cycle while the output is not stalled; each item
// passes through the operand register, front end, normaliser and
// rounder/output register in that order.
// All stages advance together on out_ready or on an empty output slot.
`default_nettype none
module fp8_e4m3_arith_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_action,
  input  wire logic [7:0] in_operand_a,
  input  wire logic [7:0] in_operand_b,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_result_value
);

  logic [3:0]     v_r, v_nxt;
  logic           adv;
  logic [2:0]     act_r;
  logic [7:0]     a_r, b_r;
  fp8a_pkg::pre_t f_pre, f_r, n_pre, n_r;
  logic [7:0]     rnd, res_r;

  assign adv       = !v_r[3] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v_r[3];
  assign out_result_value = res_r;

  fp8a_front u_front (.action(act_r), .a(a_r), .b(b_r), .pre(f_pre));
  fp8a_norm  u_norm  (.pre_in(f_r), .pre_out(n_pre));
  fp8a_round u_round (.pre(n_r), .res(rnd));

  always_comb begin
    v_nxt = adv ? {v_r[2:0], in_valid} : v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act_r <= in_action;
      a_r   <= in_operand_a;
      b_r   <= in_operand_b;
      f_r   <= f_pre;
      n_r   <= n_pre;
      res_r <= rnd;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value))
    else $error("result changed while stalled");
  a_neg: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v_r[2] && n_r.done |=> res_r == $past(n_r.fixed))
    else $error("special result lost");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted item not tracked");

endmodule
`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// FP8 E4M3 arithmetic unit testbench
// Drives directed and random operations through the valid/ready input
// channel with random gaps and output stalls, predicts each rounded result
// and compares the results in order against the predictions.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] opa;
    logic [7:0] opb;
    logic       hold;
  } op_item_t;

  localparam int CycleLimit = 200000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_action = '0;
  logic [7:0] in_operand_a = '0;
  logic [7:0] in_operand_b = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_result_value;

  op_item_t    pending_ops[$];
  logic [7:0]  expected_values[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          stim_done = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;

  fp8_e4m3_arith_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_value(out_result_value)
  );

  always #6 clk = ~clk;

  function automatic bit fp_is_nan(logic [7:0] x);
    return x[6:0] == 7'h7F;
  endfunction

  function automatic bit fp_is_zero(logic [7:0] x);
    return x[6:0] == 7'h00;
  endfunction

  function automatic void fp_split(logic [7:0] x, output int m, output int e);
    m = x & fp8a_pkg::ManMask;
    if (x[6:3] != 0) begin
      m = m | (1 << fp8a_pkg::ManBits);
      e = int'(x[6:3]) - fp8a_pkg::ExpBias;
    end else begin
      e = 1 - fp8a_pkg::ExpBias;
    end
  endfunction

  function automatic void fp_lift(inout int m, inout int e);
    for (int i = 0; i < 4 && m < 8; i++) begin
      m = m << 1;
      e = e - 1;
    end
  endfunction

  function automatic logic [7:0] fp_round(bit sign, int e, int m, bit st);
    bit sub;
    int sh;
    int inc;
    sub = 1'b0;
    if (m == 0) return {sign, 7'h00};
    while (m >= 128) begin
      st = st | m[0];
      m = m >> 1;
      e++;
    end
    for (int i = 0; i < 8 && m < 64; i++) begin
      m = m << 1;
      e--;
    end
    if (e < 1 - fp8a_pkg::ExpBias - fp8a_pkg::ManBits - 1) return {sign, 7'h00};
    if (e < 1 - fp8a_pkg::ExpBias) begin
      sh = 1 - fp8a_pkg::ExpBias - e;
      st = st | ((m & ((1 << sh) - 1)) != 0);
      m = m >> sh;
      sub = 1'b1;
    end
    st = st | m[0];
    inc = (m[2] && (m[1] || st || m[3])) ? 1 : 0;
    m = (m >> 3) + inc;
    if (sub) begin
      if (m >= 8) return {sign, 7'h08};
      return {sign, 4'h0, m[2:0]};
    end
    if (m >= 16) begin
      m = m >> 1;
      e++;
    end
    e = e + fp8a_pkg::ExpBias;
    if (e > fp8a_pkg::ExpFieldMax) return sign ? fp8a_pkg::NanNeg : fp8a_pkg::NanPos;
    return {sign, e[3:0], m[2:0]};
  endfunction

  function automatic int sticky_shift(int m, int sh);
    if (sh > 7) return (m != 0) ? 1 : 0;
    return (m >> sh) | (((m & ((1 << sh) - 1)) != 0) ? 1 : 0);
  endfunction

  function automatic logic [7:0] fp_sum(logic [7:0] a, logic [7:0] b);
    int ma, mb, ea, eb, r;
    bit sign;
    if (fp_is_nan(a)) return a;
    if (fp_is_nan(b)) return b;
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    ma = ma << 3;
    mb = mb << 3;
    if (ea > eb) begin
      mb = sticky_shift(mb, ea - eb);
      eb = ea;
    end else if (eb > ea) begin
      ma = sticky_shift(ma, eb - ea);
      ea = eb;
    end
    if (a[7] == b[7]) begin
      r = ma + mb;
      sign = a[7];
    end else if (ma > mb) begin
      r = ma - mb;
      sign = a[7];
    end else begin
      r = mb - ma;
      sign = b[7];
    end
    if (r == 0) return 8'h00;
    return fp_round(sign, ea, r, 1'b0);
  endfunction

  function automatic logic [7:0] fp_product(logic [7:0] a, logic [7:0] b);
    int ma, mb, ea, eb;
    if (fp_is_nan(a) || fp_is_nan(b)) return fp8a_pkg::NanPos;
    if (fp_is_zero(a) || fp_is_zero(b)) return 8'h00;
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    fp_lift(ma, ea);
    fp_lift(mb, eb);
    return fp_round(a[7] ^ b[7], ea + eb, ma * mb, 1'b0);
  endfunction

  function automatic logic [7:0] fp_quotient(logic [7:0] a, logic [7:0] b);
    int ma, mb, ea, eb, num, q;
    bit sign;
    bit st;
    sign = a[7] ^ b[7];
    if (fp_is_nan(a)) return a;
    if (fp_is_nan(b)) return b;
    if (fp_is_zero(a) && fp_is_zero(b)) return fp8a_pkg::NanPos;
    if (fp_is_zero(b)) return sign ? fp8a_pkg::NanNeg : fp8a_pkg::NanPos;
    if (fp_is_zero(a)) return 8'h00;
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    fp_lift(ma, ea);
    fp_lift(mb, eb);
    num = ma << (2 * fp8a_pkg::ManBits + 3);
    q = num / mb;
    st = ((q & 7) != 0) || ((num % mb) != 0);
    return fp_round(sign, ea - eb, q >> 3, st);
  endfunction

  function automatic logic [7:0] fp_result(logic [2:0] act, logic [7:0] a, logic [7:0] b);
    case (act)
      fp8a_pkg::ACT_ADD: return fp_sum(a, b);
      fp8a_pkg::ACT_SUB: begin
        if ((a == fp8a_pkg::NanPos && b == fp8a_pkg::NanNeg) ||
            (a == fp8a_pkg::NanNeg && b == fp8a_pkg::NanPos)) return fp8a_pkg::NanPos;
        return fp_sum(a, b ^ 8'h80);
      end
      fp8a_pkg::ACT_MUL: return fp_product(a, b);
      fp8a_pkg::ACT_DIV: return fp_quotient(a, b);
      fp8a_pkg::ACT_NEG: return a ^ 8'h80;
      default: return fp8a_pkg::NanPos;
    endcase
  endfunction

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return {1'($urandom), 7'h7F};
      1: return {1'($urandom), 7'h00};
      2: return {1'($urandom), 4'h0, 3'($urandom)};
      3: return {1'($urandom), 4'hF, 3'($urandom_range(0, 6))};
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] rand_action();
    if ($urandom_range(0, 19) == 0) return 3'($urandom_range(5, 7));
    return 3'($urandom_range(0, 4));
  endfunction

  task automatic queue_op(logic [2:0] act, logic [7:0] a, logic [7:0] b, bit hold);
    pending_ops.push_back('{action: act, opa: a, opb: b, hold: hold});
  endtask

  initial begin
    logic [7:0] edge_vals[8];
    edge_vals = '{8'h00, 8'h80, 8'h01, 8'h7E, 8'hFE, 8'h7F, 8'hFF, 8'h08};
    for (int i = 0; i < 8; i++) begin
      queue_op(fp8a_pkg::ACT_ADD, edge_vals[i], edge_vals[7 - i], 1'b0);
    end
    queue_op(fp8a_pkg::ACT_SUB, 8'h7F, 8'hFF, 1'b0);
    queue_op(fp8a_pkg::ACT_SUB, 8'h38, 8'h38, 1'b0);
    queue_op(fp8a_pkg::ACT_SUB, 8'h10, 8'h7F, 1'b0);
    queue_op(fp8a_pkg::ACT_MUL, 8'h7E, 8'h7E, 1'b0);
    queue_op(fp8a_pkg::ACT_MUL, 8'h01, 8'h01, 1'b0);
    queue_op(fp8a_pkg::ACT_MUL, 8'h01, 8'h30, 1'b0);
    queue_op(fp8a_pkg::ACT_MUL, 8'h80, 8'h38, 1'b0);
    queue_op(fp8a_pkg::ACT_MUL, 8'hFF, 8'h38, 1'b0);
    queue_op(fp8a_pkg::ACT_DIV, 8'h00, 8'h80, 1'b0);
    queue_op(fp8a_pkg::ACT_DIV, 8'hB8, 8'h00, 1'b0);
    queue_op(fp8a_pkg::ACT_DIV, 8'h01, 8'h7E, 1'b0);
    queue_op(fp8a_pkg::ACT_DIV, 8'h7E, 8'h01, 1'b0);
    queue_op(fp8a_pkg::ACT_DIV, 8'h38, 8'hFF, 1'b0);
    queue_op(fp8a_pkg::ACT_NEG, 8'h00, 8'hFF, 1'b0);
    queue_op(fp8a_pkg::ACT_NEG, 8'hFF, 8'h00, 1'b0);
    queue_op(3'd5, 8'h38, 8'h38, 1'b0);
    queue_op(3'd7, 8'hAA, 8'h55, 1'b1);
    for (int i = 0; i < 1950; i++) begin
      queue_op(rand_action(), rand_operand(), rand_operand(), (i % 500) == 499);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("fp8_e4m3_arith_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    op_item_t nxt;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_values.push_back(fp_result(in_action, in_operand_a, in_operand_b));
      end
      if (in_valid && !in_ready) begin
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].hold && expected_values.size() != 0)) begin
        nxt = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_action <= nxt.action;
        in_operand_a <= nxt.opa;
        in_operand_b <= nxt.opb;
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
        if (pending_ops.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result item %02h", out_result_value);
        end else begin
          want = expected_values.pop_front();
          if (out_result_value !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("result mismatch: expected %02h, got %02h", want, out_result_value);
            end
          end
        end
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        out_stall <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (expected_values.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_values.size() == 0) begin
      $display("fp8_e4m3_arith_unit verification clean");
    end else begin
      $display("fp8_e4m3_arith_unit verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/fp8a_pkg.sv
src/fp8a_front.sv
src/fp8a_norm.sv
src/fp8a_round.sv
src/fp8_e4m3_arith_unit.sv
bench/testbench.sv
